@@ hdl/dsum_pkg.sv @@
// Shared types and constants of the divisor sum unit.
package dsum_pkg;

	// result width and its byte-padded stream width
	localparam int TOTAL_WIDTH       = 36;
	localparam int TOTAL_TDATA_WIDTH = 40;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_DIV,
		ST_ACC,
		ST_DONE
	} dsum_state_t;

endpackage

@@ hdl/divisor_sum_unit.sv @@
// Divisor sum unit: sigma(n) by trial division with a bit-serial divider.
// The trial divisors run i = 2 while i*i <= n, T = max(floor(sqrt(n)) - 1, 0) of them; each steps
// through TEST, DIV and ACC, and after the last one DONE loads the result once the output register is free.
// Each trial divisor runs through the one-bit-per-cycle divider.
// Throughput: one number at a time; a new beat is taken once the result sits in the output
// register, so the next number overlaps the wait for the result to be taken.
// Reset: arst_n clears the sequencer, the divider count and m_tvalid at once; data registers keep their value.
module divisor_sum_unit import dsum_pkg::*; #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     s_tdata,  // [NUMBER_WIDTH-1:0] number
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [TOTAL_TDATA_WIDTH-1:0]          m_tdata   // [35:0] divisor_total
);

	localparam int IW = (NUMBER_WIDTH + 1) / 2 + 1;
	localparam int SW = NUMBER_WIDTH + 2;
	localparam int TW = TOTAL_WIDTH;

	dsum_state_t                state_q, state_d;
	logic                       div_start;
	logic                       div_done;
	logic [NUMBER_WIDTH-1:0]    n_q;
	logic [IW-1:0]              i_q;
	logic [SW-1:0]              sq_q;
	logic [TW-1:0]              acc_q;
	logic [TW-1:0]              total_q;
	logic                       m_tvalid_q;
	logic [NUMBER_WIDTH-1:0]    quotient;
	logic [IW-1:0]              remainder;
	logic                       in_beat;
	logic                       load_out;
	logic                       trial_on;
	logic [TW+NUMBER_WIDTH-1:0] co_wide;
	logic [TW+NUMBER_WIDTH-1:0] n_wide;
	logic [TW-1:0]              co_term;
	logic [TW-1:0]              i_term;
	logic [TW-1:0]              total_d;

	// trial divisor while i*i stays within the number
	assign trial_on = (n_q > NUMBER_WIDTH'(1)) && (sq_q <= {2'b00, n_q});

	// sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_TEST;
			end
			ST_TEST: begin
				if (trial_on) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = ST_TEST;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign in_beat = s_tvalid && s_tready;

	// divider for quotient and remainder of n by i
	dsum_div #(
		.NUMBER_WIDTH  (NUMBER_WIDTH),
		.DIVISOR_WIDTH (IW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.done      (div_done),
		.dividend  (n_q),
		.divisor   (i_q),
		.quotient  (quotient),
		.remainder (remainder)
	);

	// fit cofactor and number to the result width, wrapping when wider
	always_comb begin
		co_wide = {{TW{1'b0}}, quotient};
		n_wide  = {{TW{1'b0}}, n_q};
		i_term  = {{(TW-IW){1'b0}}, i_q};
		co_term = (quotient != {{(NUMBER_WIDTH-IW){1'b0}}, i_q}) ? co_wide[TW-1:0] : '0;
		total_d = (n_q > NUMBER_WIDTH'(1)) ? acc_q + n_wide[TW-1:0] + TW'(1) : TW'(1);
	end

	// hold the number, advance the trial divisor and its square, add found divisors
	always_ff @(posedge clk) begin
		if (in_beat) begin
			n_q   <= s_tdata[NUMBER_WIDTH-1:0];
			i_q   <= IW'(2);
			sq_q  <= SW'(4);
			acc_q <= '0;
		end else if (state_q == ST_ACC) begin
			i_q  <= i_q + IW'(1);
			sq_q <= sq_q + {{(SW-IW-1){1'b0}}, i_q, 1'b1};
			if (remainder == '0)
				acc_q <= acc_q + i_term + co_term;
		end
	end

	// output register, parted from the input side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (load_out)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			total_q <= total_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TOTAL_TDATA_WIDTH-TW){1'b0}}, total_q};

endmodule

@@ hdl/dsum_div.sv @@
// Bit-serial restoring divider: quotient and remainder, one bit per cycle.
module dsum_div import dsum_pkg::*; #(
	parameter int NUMBER_WIDTH  = 32,
	parameter int DIVISOR_WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     done,
	input  logic [NUMBER_WIDTH-1:0]  dividend,
	input  logic [DIVISOR_WIDTH-1:0] divisor,
	output logic [NUMBER_WIDTH-1:0]  quotient,
	output logic [DIVISOR_WIDTH-1:0] remainder
);

	localparam int CW = $clog2(NUMBER_WIDTH + 1);

	logic [CW-1:0]              cnt_q;
	logic                       done_q;
	logic [NUMBER_WIDTH-1:0]    dq_q;
	logic [DIVISOR_WIDTH-1:0]   rem_q;
	logic [DIVISOR_WIDTH:0]     trial;
	logic [DIVISOR_WIDTH:0]     diff;
	logic                       fits;

	// bring down the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, dq_q[NUMBER_WIDTH-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	// count the shifts and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NUMBER_WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	// shift dividend out and quotient in through the same register
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dq_q  <= {dq_q[NUMBER_WIDTH-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

@@ hdl/dsum_chk.sv @@
// Port checker for the divisor sum unit, bound to the top level.
module dsum_chk import dsum_pkg::*; #(
	parameter int NUMBER_WIDTH = 32
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [((NUMBER_WIDTH+7)/8)*8-1:0] s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [TOTAL_TDATA_WIDTH-1:0]      m_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// the unit is busy right after taking a number
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// every divisor sum counts at least the divisor 1
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TOTAL_WIDTH-1:0] != '0)
		else $error("zero divisor sum");

	// padding bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TOTAL_TDATA_WIDTH-1:TOTAL_WIDTH] == '0)
		else $error("padding bits set");

endmodule

bind divisor_sum_unit dsum_chk #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_dsum_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the divisor sum unit: directed table, then random numbers.
module tb_top;
	import dsum_pkg::*;

	localparam int NUMBER_WIDTH    = 32;
	localparam int S_TDATA_WIDTH   = ((NUMBER_WIDTH + 7) / 8) * 8;
	localparam int DIRECTED_COUNT  = 21;
	localparam int RANDOM_COUNT    = 80;
	localparam int HOLD_AT         = DIRECTED_COUNT + 10;
	localparam int HOLD_OFF_CYCLES = 50000;
	localparam int DRAIN_CYCLES    = 100;
	localparam longint CYCLE_LIMIT = 12000000;

	// one row of the directed table; total is only used when fixed is set
	typedef struct packed {
		logic [NUMBER_WIDTH-1:0] number;
		logic                    fixed;
		logic [TOTAL_WIDTH-1:0]  total;
	} number_row_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [S_TDATA_WIDTH-1:0]     s_tdata  = '0;  // [31:0] number
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [TOTAL_TDATA_WIDTH-1:0] m_tdata;        // [35:0] divisor_total

	logic [TOTAL_WIDTH-1:0] totals_due [$];
	int     fail_count    = 0;
	int     results_taken = 0;
	longint cycle_count   = 0;

	// extremes, squares, primes, perfect and highly composite numbers
	number_row_t directed_rows [0:DIRECTED_COUNT-1] = '{
		'{32'd1,          1'b1, 36'd1},
		'{32'd0,          1'b1, 36'd1},
		'{32'd2,          1'b1, 36'd3},
		'{32'd3,          1'b0, 36'd0},
		'{32'd4,          1'b0, 36'd0},
		'{32'd6,          1'b0, 36'd0},
		'{32'd12,         1'b0, 36'd0},
		'{32'd16,         1'b0, 36'd0},
		'{32'd28,         1'b0, 36'd0},
		'{32'd36,         1'b0, 36'd0},
		'{32'd49,         1'b0, 36'd0},
		'{32'd97,         1'b0, 36'd0},
		'{32'd120,        1'b0, 36'd0},
		'{32'd720720,     1'b0, 36'd0},
		'{32'd1024,       1'b0, 36'd0},
		'{32'd65535,      1'b0, 36'd0},
		'{32'd65536,      1'b0, 36'd0},
		'{32'd999983,     1'b0, 36'd0},
		'{32'd1000000,    1'b0, 36'd0},
		'{32'hFFFF_FFFF,  1'b1, 36'd7304603328},
		'{32'd5,          1'b0, 36'd0}
	};

	divisor_sum_unit #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// sum of all divisors by trial division up to the square root
	function automatic logic [TOTAL_WIDTH-1:0] divisor_total_of(input logic [NUMBER_WIDTH-1:0] number);
		longint unsigned n;
		longint unsigned trial;
		longint unsigned cofactor;
		longint unsigned sum;
		n = 64'(number);
		if (n <= 1)
			return TOTAL_WIDTH'(1);
		sum = n + 1;
		for (trial = 2; trial * trial <= n; trial++) begin
			if (n % trial == 0) begin
				cofactor = n / trial;
				sum += (cofactor != trial) ? trial + cofactor : trial;
			end
		end
		return sum[TOTAL_WIDTH-1:0];
	endfunction

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// offer one number, hold it until taken, then record the total it is due
	task automatic send_number(input logic [NUMBER_WIDTH-1:0] number, input logic fixed,
			input logic [TOTAL_WIDTH-1:0] total);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= number;
		do @(posedge clk); while (!s_tready);
		totals_due.push_back(fixed ? total : divisor_total_of(number));
	endtask

	// stimulus: reset, directed table, random numbers, drain
	initial begin
		int r;
		logic [NUMBER_WIDTH-1:0] n;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[k])
			send_number(directed_rows[k].number, directed_rows[k].fixed, directed_rows[k].total);
		// keep most numbers small so the trial loop stays short
		repeat (RANDOM_COUNT) begin
			r = $urandom_range(99);
			if (r < 85)
				n = $urandom_range(4095, 1);
			else
				n = $urandom_range(1 << 20, 4096);
			send_number(n, 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (totals_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// receiver: random stalls, and one long hold-off to back the unit up
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && results_taken >= HOLD_AT) begin
				held = 1'b1;
				gap  = HOLD_OFF_CYCLES;
			end else begin
				gap = pick_gap();
			end
			if (gap > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// check each result beat against the oldest total due
	always @(posedge clk) begin
		logic [TOTAL_WIDTH-1:0] due;
		if (arst_n && m_tvalid && m_tready) begin
			results_taken++;
			if (totals_due.size() == 0) begin
				$error("divisor_total: unexpected beat, expected none, actual %0d",
					m_tdata[TOTAL_WIDTH-1:0]);
				fail_count++;
			end else begin
				due = totals_due.pop_front();
				if (m_tdata[TOTAL_WIDTH-1:0] !== due) begin
					$error("divisor_total: expected %0d, actual %0d", due,
						m_tdata[TOTAL_WIDTH-1:0]);
					fail_count++;
				end
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

endmodule

@@ sim.f @@
hdl/dsum_pkg.sv
hdl/dsum_div.sv
hdl/divisor_sum_unit.sv
hdl/dsum_chk.sv
tb/tb_top.sv
